### design/yaml_token_scanner_defines.svh
// Assertion macros for the checker file of the YAML token scanner.
`ifndef YAML_TOKEN_SCANNER_DEFINES_SVH
`define YAML_TOKEN_SCANNER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define YTS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("yaml_token_scanner: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define YTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("yaml_token_scanner: next-cycle check failed");

`endif

### design/yts_pkg.sv
// Types, codes and character helpers of the YAML token scanner.
package yts_pkg;

  // Token kinds on the result channel.
  localparam logic [3:0] KIND_VALUE     = 4'd0;
  localparam logic [3:0] KIND_HYPHEN    = 4'd1;
  localparam logic [3:0] KIND_MAPPER    = 4'd2;
  localparam logic [3:0] KIND_COMMENT   = 4'd3;
  localparam logic [3:0] KIND_EOL       = 4'd4;
  localparam logic [3:0] KIND_INDENT    = 4'd5;
  localparam logic [3:0] KIND_FOLDED    = 4'd6;
  localparam logic [3:0] KIND_LITERAL   = 4'd7;
  localparam logic [3:0] KIND_PLAIN_END = 4'd8;
  localparam logic [3:0] KIND_TRUE      = 4'd9;
  localparam logic [3:0] KIND_FALSE     = 4'd10;
  localparam logic [3:0] KIND_NULL      = 4'd11;
  localparam logic [3:0] KIND_QUOTE_END = 4'd12;
  localparam logic [3:0] KIND_QUOTE_ERR = 4'd13;
  localparam logic [3:0] KIND_END       = 4'd14;

  // Scanner modes.
  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_PLAIN = 3'd1;
  localparam logic [2:0] MODE_DQ    = 3'd2;
  localparam logic [2:0] MODE_SQ    = 3'd3;
  localparam logic [2:0] MODE_END   = 3'd4;

  // Keyword slots in the match vector.
  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;
  localparam int         KW_COUNT = 3;

  localparam logic [2:0] LEN_MAX = 3'd7;

  // Characters.
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // Result queue geometry.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] value;
    logic       last;
  } token_t;

  // Up to two tokens pushed into the result queue per scanned item.
  typedef struct packed {
    logic   push0;
    logic   push1;
    token_t tok0;
    token_t tok1;
  } push_t;

  function automatic token_t mk_tok(input logic [3:0] kind, input logic [7:0] b,
                                    input logic lst);
    token_t t;
    t.kind  = kind;
    t.value = (kind == KIND_VALUE) ? b : 8'h00;
    t.last  = lst;
    return t;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_plain_start(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || (c == CH_DOT);
  endfunction

  // True when keyword idx has character lc at position pos.
  function automatic logic kw_hit(input logic [1:0] idx, input logic [2:0] pos,
                                  input logic [7:0] lc);
    logic [7:0] ch;
    logic       ok;
    ch = 8'h00;
    ok = 1'b1;
    unique case (idx)
      KW_TRUE: begin
        unique case (pos)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ok = 1'b0;
        endcase
      end
      KW_FALSE: begin
        unique case (pos)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ok = 1'b0;
        endcase
      end
      KW_NULL: begin
        unique case (pos)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ok = 1'b0;
        endcase
      end
      default: ok = 1'b0;
    endcase
    return ok && (ch == lc);
  endfunction

endpackage

### design/yts_scanner.sv
// Input register, scanner state and per-byte token decode.
module yts_scanner import yts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  input  logic       room,
  output push_t      push
);

  logic       st_valid;
  logic [7:0] st_byte;
  logic       st_eoi;

  logic [2:0] mode, mode_next;
  logic       skip, skip_next;
  logic [2:0] len, len_next;
  logic [2:0] kmatch, kmatch_next;

  logic       advance;
  logic [7:0] lc;
  logic [2:0] first_km, step_km;
  logic [2:0] len_inc;

  // Start-mode decode of the staged byte.
  logic       s_emit;
  token_t     s_tok;
  logic [2:0] s_mode;
  logic       s_plain;
  logic       s_quote;

  logic       term;
  logic [3:0] end_kind;
  logic [7:0] quote_ch;
  push_t      raw;

  assign in_ready = !st_valid || room;
  assign advance  = st_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_ready) begin
      st_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      st_byte <= in_byte;
      st_eoi  <= end_of_input;
    end
  end

  assign lc      = to_lower(st_byte);
  assign len_inc = (len < LEN_MAX) ? len + 3'd1 : len;

  always_comb begin
    for (int i = 0; i < KW_COUNT; i++) begin
      first_km[i] = kw_hit(2'(i), 3'd0, lc);
      step_km[i]  = kmatch[i] && kw_hit(2'(i), len, lc);
    end
  end

  always_comb begin
    s_emit  = 1'b1;
    s_mode  = MODE_START;
    s_plain = 1'b0;
    s_quote = 1'b0;
    s_tok   = mk_tok(KIND_END, 8'h00, 1'b1);
    if (st_eoi) begin
      s_mode = MODE_END;
    end else begin
      unique case (st_byte)
        CH_PIPE:   s_tok = mk_tok(KIND_LITERAL, 8'h00, 1'b1);
        CH_GT:     s_tok = mk_tok(KIND_FOLDED, 8'h00, 1'b1);
        CH_COLON:  s_tok = mk_tok(KIND_MAPPER, 8'h00, 1'b1);
        CH_HYPHEN: s_tok = mk_tok(KIND_HYPHEN, 8'h00, 1'b1);
        CH_HASH:   s_tok = mk_tok(KIND_COMMENT, 8'h00, 1'b1);
        CH_LF:     s_tok = mk_tok(KIND_EOL, 8'h00, 1'b1);
        CH_SPACE:  s_tok = mk_tok(KIND_INDENT, 8'h00, 1'b1);
        CH_DQUOTE: begin
          s_emit  = 1'b0;
          s_mode  = MODE_DQ;
          s_quote = 1'b1;
        end
        CH_SQUOTE: begin
          s_emit  = 1'b0;
          s_mode  = MODE_SQ;
          s_quote = 1'b1;
        end
        default: begin
          if (is_plain_start(st_byte)) begin
            s_mode  = MODE_PLAIN;
            s_plain = 1'b1;
            s_tok   = mk_tok(KIND_VALUE, st_byte, 1'b1);
          end else begin
            s_emit = 1'b0;
          end
        end
      endcase
    end
  end

  assign term = st_eoi || (st_byte == CH_LF) || (st_byte == CH_COLON) ||
                (st_byte == CH_HASH);

  always_comb begin
    priority if (kmatch[KW_TRUE] && len == 3'd4) begin
      end_kind = KIND_TRUE;
    end else if (kmatch[KW_FALSE] && len == 3'd5) begin
      end_kind = KIND_FALSE;
    end else if (kmatch[KW_NULL] && len == 3'd4) begin
      end_kind = KIND_NULL;
    end else begin
      end_kind = KIND_PLAIN_END;
    end
  end

  assign quote_ch = (mode == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    mode_next   = mode;
    skip_next   = skip;
    len_next    = len;
    kmatch_next = kmatch;
    raw         = '0;
    unique case (mode)
      MODE_END: begin
        raw.push0 = 1'b1;
        raw.tok0  = mk_tok(KIND_END, 8'h00, 1'b1);
      end
      MODE_PLAIN: begin
        if (term) begin
          // Close the scalar, then rescan the terminator from start mode.
          raw.push0   = 1'b1;
          raw.tok0    = mk_tok(end_kind, 8'h00, 1'b0);
          raw.push1   = 1'b1;
          raw.tok1    = s_tok;
          mode_next   = s_mode;
          len_next    = 3'd0;
          kmatch_next = 3'b111;
        end else if (st_byte != CH_CR) begin
          len_next    = len_inc;
          kmatch_next = step_km;
          raw.push0   = 1'b1;
          raw.tok0    = mk_tok(KIND_VALUE, st_byte, 1'b1);
        end
      end
      MODE_DQ, MODE_SQ: begin
        priority if (st_eoi) begin
          raw.push0 = 1'b1;
          raw.tok0  = mk_tok(KIND_QUOTE_ERR, 8'h00, 1'b1);
          mode_next = MODE_END;
          skip_next = 1'b0;
        end else if (st_byte == quote_ch) begin
          raw.push0 = 1'b1;
          raw.tok0  = mk_tok(KIND_QUOTE_END, 8'h00, 1'b1);
          mode_next = MODE_START;
          skip_next = 1'b0;
        end else if (st_byte == CH_CR) begin
          raw.push0 = 1'b0;
        end else if (skip && st_byte == CH_SPACE) begin
          raw.push0 = 1'b0;
        end else begin
          skip_next = (st_byte == CH_LF);
          raw.push0 = 1'b1;
          raw.tok0  = mk_tok(KIND_VALUE, st_byte, 1'b1);
        end
      end
      default: begin
        mode_next = s_mode;
        if (s_plain) begin
          len_next    = 3'd1;
          kmatch_next = first_km;
        end
        if (s_quote) begin
          skip_next = 1'b0;
        end
        raw.push0 = s_emit;
        raw.tok0  = s_tok;
      end
    endcase
  end

  always_comb begin
    push       = raw;
    push.push0 = raw.push0 && advance;
    push.push1 = raw.push1 && advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_START;
      skip   <= 1'b0;
      len    <= 3'd0;
      kmatch <= 3'b111;
    end else if (advance) begin
      mode   <= mode_next;
      skip   <= skip_next;
      len    <= len_next;
      kmatch <= kmatch_next;
    end
  end

endmodule

### design/yts_result_fifo.sv
// Result queue: takes up to two tokens per cycle, hands out one.
module yts_result_fifo import yts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] token_kind,
  output logic [7:0] value_byte,
  output logic       last
);

  token_t         mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count, count_next;
  logic           pop;
  logic [QAW:0]   n_push;
  token_t         head;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count <= (QAW+1)'(QDEPTH - 2));
  assign n_push    = (QAW+1)'(push.push0) + (QAW+1)'(push.push1);
  assign count_next = count + n_push - (QAW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[wr_ptr] <= push.tok0;
    end
    if (push.push1) begin
      mem[wr_ptr + QAW'(1)] <= push.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[QAW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count_next;
    end
  end

  assign head       = mem[rd_ptr];
  assign token_kind = head.kind;
  assign value_byte = head.value;
  assign last       = head.last;

endmodule

### design/yaml_token_scanner.sv
// Top level of the YAML token scanner: input stage, scanner and result queue.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one character per transaction in
//   in_byte, or an end-of-input mark when end_of_input is high. Output channel
//   (out_valid/out_ready) carries one token event per transaction: token_kind,
//   value_byte (nonzero only for scalar bytes) and last, which flags the final
//   token caused by one input transaction. An input causes zero, one or two
//   tokens; two only where a terminator closes a plain scalar.
//   Data path: a byte is registered on acceptance, decoded from the staged
//   register and written into a four-entry result queue, which then offers
//   its first token. Throughput: one input per cycle while the receiver
//   keeps up. An item that closes a plain scalar yields two tokens while
//   the receiver takes one per transaction, so a long run of such items
//   fills the queue and stalls the input side.
//   in_ready depends only on registered state: the staged byte moves on
//   whenever the queue has room for two tokens.
//   Reset (rst, synchronous): empties the stage and queue and returns the
//   scanner to start mode. Receiver stall: tokens wait in the queue with
//   payload held; once the queue is nearly full the input side stalls too.
module yaml_token_scanner import yts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] token_kind,
  output logic [7:0] value_byte,
  output logic       last
);

  push_t push;
  logic  room;

  // Stage the byte, track mode and keyword match, build up to two tokens.
  yts_scanner u_scanner (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .room         (room),
    .push         (push)
  );

  // Hold tokens until the receiver takes them.
  yts_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .token_kind (token_kind),
    .value_byte (value_byte),
    .last       (last)
  );

endmodule

### design/yts_checker.sv
// Port-level checks of the YAML token scanner, bound to the top level.
`include "yaml_token_scanner_defines.svh"

module yts_checker import yts_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] token_kind,
  input logic [7:0] value_byte,
  input logic       last
);

  logic out_stall;
  logic close_kind;
  logic end_taken;

  assign out_stall  = out_valid && !out_ready;
  assign close_kind = (token_kind == KIND_PLAIN_END) || (token_kind == KIND_TRUE) ||
                      (token_kind == KIND_FALSE) || (token_kind == KIND_NULL);
  assign end_taken  = out_valid && out_ready && (token_kind == KIND_END);

  `YTS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable({token_kind, value_byte, last}))

  `YTS_ASSERT_IMPL(a_value_zero, out_valid && token_kind != KIND_VALUE, value_byte == 8'h00)

  `YTS_ASSERT_IMPL(a_scalar_close_not_last, out_valid && close_kind, !last)

  `YTS_ASSERT_IMPL(a_value_last, out_valid && token_kind == KIND_VALUE, last)

  `YTS_ASSERT_NEXT(a_end_sticky, end_taken, !out_valid || token_kind == KIND_END)

endmodule

bind yaml_token_scanner yts_checker u_yts_checker (.*);
